>>> design/round_robin_slice_scheduler_defines.svh
// Assertion macros used by the checker file of the round-robin slice scheduler.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ROUND_ROBIN_SLICE_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_SLICE_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RRSS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RRSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rrss_pkg.sv
// Shared types and constants of the round-robin slice scheduler.
// No dependencies; used by every module of the block.
package rrss_pkg;

  localparam int unsigned IdW    = 16;
  localparam int unsigned RemW   = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 5;
  localparam int unsigned CfgW   = 16;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_RUN   = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_LEN = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic {
    CFG_QUANTUM = 1'b0,
    CFG_FIFO    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [RemW-1:0] rem;
  } entry_t;

  typedef struct packed {
    logic   en;
    entry_t data;
  } mem_wr_t;

  typedef struct packed {
    status_e           status;
    logic [IdW-1:0]    slice_process_id;
    logic [TimeW-1:0]  slice_start;
    logic [TimeW-1:0]  slice_end;
    logic [RemW-1:0]   remaining_before;
    logic              process_finished;
    logic [CountW-1:0] queue_count;
  } result_t;

endpackage

>>> design/rrss_queue_mem.sv
// Ready-queue storage: one write port and one registered read port.
// Depends on rrss_pkg for the entry and write-request types.
module rrss_queue_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                clk_i,
  input  rrss_pkg::mem_wr_t   wr_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  output rrss_pkg::entry_t    rd_entry_o
);

  rrss_pkg::entry_t mem_q [Depth];
  rrss_pkg::entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_addr_i] <= wr_i.data;
    end
  end

  // A write to the address being read this cycle is forwarded, so the read
  // register always mirrors the entry at the new head.
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_addr_i == rd_addr_i)) begin
      rd_q <= wr_i.data;
    end else begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_entry_o = rd_q;

endmodule

>>> design/rrss_sched_core.sv
// Scheduler state (head, tail, count, time) and the per-operation logic.
// Depends on rrss_pkg; drives the rrss_queue_mem ports.
module rrss_sched_core #(
  parameter int unsigned QueueDepth = 16,
  parameter int unsigned AddrW      = 4,
  parameter int unsigned CntW       = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  rrss_pkg::op_e                 op_i,
  input  logic [rrss_pkg::IdW-1:0]      pid_i,
  input  logic [rrss_pkg::RemW-1:0]     burst_i,
  input  logic [rrss_pkg::CfgW-1:0]     quantum_i,
  input  logic                          fifo_i,
  input  rrss_pkg::entry_t              head_i,
  output rrss_pkg::mem_wr_t             mem_wr_o,
  output logic [AddrW-1:0]              mem_waddr_o,
  output logic [AddrW-1:0]              mem_raddr_o,
  output rrss_pkg::result_t             result_o
);

  logic [AddrW-1:0]              head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]               count_q, count_d;
  logic [rrss_pkg::TimeW-1:0]    time_q, time_d;
  logic [rrss_pkg::RemW-1:0]     quantum, slice, rem_left;
  logic [rrss_pkg::TimeW:0]      time_sum;
  logic [rrss_pkg::TimeW-1:0]    time_end;
  logic [CntW+4:0]               count_ext;
  logic                          wr_en;
  rrss_pkg::entry_t              wr_data;
  rrss_pkg::result_t             res;

  function automatic logic [AddrW-1:0] next_idx(input logic [AddrW-1:0] idx);
    next_idx = (idx == AddrW'(QueueDepth - 1)) ? '0 : idx + AddrW'(1);
  endfunction

  // A zero quantum behaves as a quantum of one.
  assign quantum  = (quantum_i == '0) ? rrss_pkg::RemW'(1) : quantum_i;
  assign slice    = fifo_i ? head_i.rem
                           : ((head_i.rem < quantum) ? head_i.rem : quantum);
  assign rem_left = head_i.rem - slice;
  assign time_sum = {1'b0, time_q} + {{(rrss_pkg::TimeW + 1 - rrss_pkg::RemW){1'b0}}, slice};
  assign time_end = time_sum[rrss_pkg::TimeW] ? '1 : time_sum[rrss_pkg::TimeW-1:0];

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    time_d  = time_q;
    wr_en   = 1'b0;
    wr_data = head_i;
    res     = '0;
    res.status = rrss_pkg::ST_OK;
    case (op_i)
      rrss_pkg::OP_ADD: begin
        if (burst_i == '0) begin
          res.status = rrss_pkg::ST_BAD_LEN;
        end else if (count_q == CntW'(QueueDepth)) begin
          res.status = rrss_pkg::ST_FULL;
        end else begin
          wr_en        = 1'b1;
          wr_data.id   = pid_i;
          wr_data.rem  = burst_i;
          tail_d       = next_idx(tail_q);
          count_d      = count_q + CntW'(1);
        end
      end
      rrss_pkg::OP_RUN: begin
        if (count_q == '0) begin
          res.status = rrss_pkg::ST_EMPTY;
        end else begin
          head_d               = next_idx(head_q);
          time_d               = time_end;
          res.slice_process_id = head_i.id;
          res.slice_start      = time_q;
          res.slice_end        = time_end;
          res.remaining_before = head_i.rem;
          if (rem_left != '0) begin
            // The popped process goes straight back to the tail.
            wr_en       = 1'b1;
            wr_data.id  = head_i.id;
            wr_data.rem = rem_left;
            tail_d      = next_idx(tail_q);
          end else begin
            count_d              = count_q - CntW'(1);
            res.process_finished = 1'b1;
          end
        end
      end
      rrss_pkg::OP_CLEAR: begin
        head_d  = '0;
        tail_d  = '0;
        count_d = '0;
        time_d  = '0;
      end
      default: begin
      end
    endcase
    count_ext       = {5'd0, count_d};
    res.queue_count = count_ext[4:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      time_q  <= '0;
    end else if (fire_i) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      time_q  <= time_d;
    end
  end

  assign mem_wr_o.en   = wr_en & fire_i;
  assign mem_wr_o.data = wr_data;
  assign mem_waddr_o   = tail_q;
  assign mem_raddr_o   = fire_i ? head_d : head_q;
  assign result_o      = res;

endmodule

>>> design/round_robin_slice_scheduler.sv
// Channel   Dir  Width  Contents
// s_axis    in   32+2   tdata: process_id, burst_length; tuser: operation
// m_axis    out  104    tdata: status .. queue_count (one word per input word)
// cfg       in   1+16   register index, write data; written when cfg_we_i is high
//
// One word is accepted per cycle while m_axis is not stalled; its result word passes
// the input register and then the output register before it is presented on m_axis.
// The rate is set by the single queue memory port pair: one head read and one tail
// write per word, with the read register holding the head entry for the next word.
// Reset is asynchronous, active low; the queue memory is not cleared and needs no pass.
// A stalled output holds its word; the input register still takes one more word.
module round_robin_slice_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // [15:0] process_id, [31:16] burst_length
  input  logic [31:0]   s_axis_tdata_i,
  // [1:0] operation
  input  logic [1:0]    s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // [1:0] status, [17:2] slice_process_id, [49:18] slice_start, [81:50] slice_end,
  // [97:82] remaining_before, [98] process_finished, [103:99] queue_count
  output logic [103:0]  m_axis_tdata_o,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [15:0]   cfg_wdata_i
);

  localparam int unsigned AddrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);

  logic                          in_valid_q;
  rrss_pkg::op_e                 in_op_q;
  logic [rrss_pkg::IdW-1:0]      in_pid_q;
  logic [rrss_pkg::RemW-1:0]     in_burst_q;
  logic                          out_valid_q;
  rrss_pkg::result_t             out_q;
  logic [rrss_pkg::CfgW-1:0]     quantum_q;
  logic                          fifo_q;
  logic                          fire, in_ready;
  rrss_pkg::result_t             result;
  rrss_pkg::entry_t              head_entry;
  rrss_pkg::mem_wr_t             mem_wr;
  logic [AddrW-1:0]              mem_waddr, mem_raddr;

  assign fire     = in_valid_q & (~out_valid_q | m_axis_tready_i);
  assign in_ready = ~in_valid_q | fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= rrss_pkg::CfgW'(1);
      fifo_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (rrss_pkg::cfg_idx_e'(cfg_idx_i))
        rrss_pkg::CFG_QUANTUM: quantum_q <= cfg_wdata_i;
        rrss_pkg::CFG_FIFO:    fifo_q    <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid_i) begin
      in_op_q    <= rrss_pkg::op_e'(s_axis_tuser_i);
      in_pid_q   <= s_axis_tdata_i[15:0];
      in_burst_q <= s_axis_tdata_i[31:16];
    end
  end

  rrss_sched_core #(
    .QueueDepth (QUEUE_DEPTH),
    .AddrW      (AddrW),
    .CntW       (CntW)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .op_i        (in_op_q),
    .pid_i       (in_pid_q),
    .burst_i     (in_burst_q),
    .quantum_i   (quantum_q),
    .fifo_i      (fifo_q),
    .head_i      (head_entry),
    .mem_wr_o    (mem_wr),
    .mem_waddr_o (mem_waddr),
    .mem_raddr_o (mem_raddr),
    .result_o    (result)
  );

  rrss_queue_mem #(
    .Depth (QUEUE_DEPTH),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i      (clk_i),
    .wr_i       (mem_wr),
    .wr_addr_i  (mem_waddr),
    .rd_addr_i  (mem_raddr),
    .rd_entry_o (head_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (~out_valid_q | m_axis_tready_i) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.queue_count, out_q.process_finished,
                            out_q.remaining_before, out_q.slice_end,
                            out_q.slice_start, out_q.slice_process_id,
                            out_q.status};

endmodule

>>> design/rrss_checker.sv
// Port-level checks of the round-robin slice scheduler, bound to the top level.
// Depends on rrss_pkg and round_robin_slice_scheduler_defines.svh.
`include "round_robin_slice_scheduler_defines.svh"

module rrss_checker #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          s_axis_tvalid_i,
  input logic          s_axis_tready_o,
  input logic [31:0]   s_axis_tdata_i,
  input logic [1:0]    s_axis_tuser_i,
  input logic          m_axis_tvalid_o,
  input logic          m_axis_tready_i,
  input logic [103:0]  m_axis_tdata_o,
  input logic          cfg_we_i,
  input logic          cfg_idx_i,
  input logic [15:0]   cfg_wdata_i
);

  logic [1:0]  status;
  logic [15:0] pid;
  logic [31:0] t_start, t_end;
  logic [15:0] rem_before;
  logic        finished;
  logic [4:0]  count;

  assign status     = m_axis_tdata_o[1:0];
  assign pid        = m_axis_tdata_o[17:2];
  assign t_start    = m_axis_tdata_o[49:18];
  assign t_end      = m_axis_tdata_o[81:50];
  assign rem_before = m_axis_tdata_o[97:82];
  assign finished   = m_axis_tdata_o[98];
  assign count      = m_axis_tdata_o[103:99];

  `RRSS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "result word changed while stalled")

  `RRSS_ASSERT_NOW(a_count_range, clk_i, rst_ni, m_axis_tvalid_o, (QUEUE_DEPTH > 31) || (32'(count) <= QUEUE_DEPTH), "queue count beyond queue depth")

  `RRSS_ASSERT_NOW(a_empty_zero, clk_i, rst_ni, m_axis_tvalid_o && (status == rrss_pkg::ST_EMPTY), (pid == '0) && (t_start == '0) && (t_end == '0) && (rem_before == '0) && !finished && (count == '0), "empty-queue result carries slice data")

  // Once the clock has reached its ceiling a slice starts and ends there.
  `RRSS_ASSERT_NOW(a_slice_order, clk_i, rst_ni, m_axis_tvalid_o && (rem_before != '0), (status == rrss_pkg::ST_OK) && ((t_end > t_start) || (t_end == '1)), "slice does not advance time")

endmodule

bind round_robin_slice_scheduler rrss_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_rrss_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .cfg_we_i        (cfg_we_i),
  .cfg_idx_i       (cfg_idx_i),
  .cfg_wdata_i     (cfg_wdata_i)
);

>>> verif/testbench.sv
// Self-checking testbench for the round-robin slice scheduler: a queue-fed word driver,
// a checking monitor and an in-bench scheduler predictor. Depends on rrss_pkg and the
// round_robin_slice_scheduler RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth          = 16;
  localparam logic [1:0]  OpReserved     = 2'd3;
  localparam int unsigned HoldOffCycles  = 80;
  localparam int unsigned QuietLimit     = 4000;
  localparam int unsigned RandomItems    = 130;
  localparam int unsigned LongSlicePairs = 4;
  localparam int unsigned MaxReports     = 10;

  typedef struct packed {
    logic [1:0]                op;
    logic [rrss_pkg::IdW-1:0]  id;
    logic [rrss_pkg::RemW-1:0] burst;
  } sched_req_t;

  logic          clk_i           = 1'b0;
  logic          rst_ni          = 1'b0;
  logic          s_axis_tvalid_i = 1'b0;
  logic          s_axis_tready_o;
  logic [31:0]   s_axis_tdata_i  = '0;
  logic [1:0]    s_axis_tuser_i  = '0;
  logic          m_axis_tvalid_o;
  logic          m_axis_tready_i = 1'b0;
  logic [103:0]  m_axis_tdata_o;
  logic          cfg_we_i        = 1'b0;
  logic          cfg_idx_i       = 1'b0;
  logic [15:0]   cfg_wdata_i     = '0;

  // Words waiting to be offered, and results that the scheduler owes us.
  sched_req_t         pending_reqs[$];
  rrss_pkg::result_t  owed_results[$];
  sched_req_t         offered_req;

  int unsigned send_idle_pct = 21;
  int unsigned recv_idle_pct = 63;
  logic        pressure_on   = 1'b0;
  int unsigned hold_count    = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned mismatches    = 0;

  // Predictor state: the ready queue, the clock and the register copies.
  logic [rrss_pkg::IdW-1:0]    ready_ids  [Depth];
  logic [rrss_pkg::RemW-1:0]   ready_left [Depth];
  int unsigned                 rd_ptr     = 0;
  int unsigned                 wr_ptr     = 0;
  int unsigned                 ready_cnt  = 0;
  logic [rrss_pkg::TimeW-1:0]  cpu_time   = '0;
  logic [rrss_pkg::CfgW-1:0]   slice_limit = 16'd1;
  logic                        run_to_completion = 1'b0;

  round_robin_slice_scheduler #(
    .QUEUE_DEPTH(Depth)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic void append_process(input logic [rrss_pkg::IdW-1:0] id,
                                         input logic [rrss_pkg::RemW-1:0] left);
    ready_ids[wr_ptr]  = id;
    ready_left[wr_ptr] = left;
    wr_ptr = (wr_ptr + 1) % Depth;
    ready_cnt++;
  endfunction

  function automatic rrss_pkg::result_t schedule_step(input sched_req_t req);
    rrss_pkg::result_t          res;
    logic [rrss_pkg::TimeW-1:0] qnt;
    logic [rrss_pkg::TimeW-1:0] left;
    logic [rrss_pkg::TimeW-1:0] run_len;
    res        = '0;
    res.status = rrss_pkg::ST_OK;
    case (req.op)
      rrss_pkg::OP_ADD: begin
        if (req.burst == '0) begin
          res.status = rrss_pkg::ST_BAD_LEN;
        end else if (ready_cnt >= Depth) begin
          res.status = rrss_pkg::ST_FULL;
        end else begin
          append_process(req.id, req.burst);
        end
      end
      rrss_pkg::OP_RUN: begin
        if (ready_cnt == 0) begin
          res.status = rrss_pkg::ST_EMPTY;
        end else begin
          res.slice_process_id = ready_ids[rd_ptr];
          left   = rrss_pkg::TimeW'(ready_left[rd_ptr]);
          rd_ptr = (rd_ptr + 1) % Depth;
          ready_cnt--;
          // A zero quantum behaves like a quantum of one.
          qnt     = (slice_limit == '0) ? 32'd1 : rrss_pkg::TimeW'(slice_limit);
          run_len = run_to_completion ? left : ((left < qnt) ? left : qnt);
          res.slice_start = cpu_time;
          if (cpu_time > 32'hFFFF_FFFF - run_len) begin
            cpu_time = 32'hFFFF_FFFF;
          end else begin
            cpu_time = cpu_time + run_len;
          end
          res.slice_end        = cpu_time;
          res.remaining_before = left[rrss_pkg::RemW-1:0];
          left = left - run_len;
          if (left != '0) begin
            append_process(res.slice_process_id, left[rrss_pkg::RemW-1:0]);
          end else begin
            res.process_finished = 1'b1;
          end
        end
      end
      rrss_pkg::OP_CLEAR: begin
        rd_ptr    = 0;
        wr_ptr    = 0;
        ready_cnt = 0;
        cpu_time  = '0;
      end
      default: begin
      end
    endcase
    res.queue_count = rrss_pkg::CountW'(ready_cnt);
    return res;
  endfunction

  function automatic string describe(input rrss_pkg::result_t r);
    return $sformatf("st=%0d id=%h start=%h end=%h rem=%h fin=%0d cnt=%0d", r.status,
                     r.slice_process_id, r.slice_start, r.slice_end, r.remaining_before,
                     r.process_finished, r.queue_count);
  endfunction

  // Driver: predicts each word as it is accepted, then offers the next one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        owed_results.push_back(schedule_step(offered_req));
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_req = pending_reqs.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {offered_req.burst, offered_req.id};
          s_axis_tuser_i  <= offered_req.op;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result word and drives the output back-pressure.
  always @(posedge clk_i) begin : monitor
    rrss_pkg::result_t got;
    rrss_pkg::result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.status           = rrss_pkg::status_e'(m_axis_tdata_o[1:0]);
        got.slice_process_id = m_axis_tdata_o[17:2];
        got.slice_start      = m_axis_tdata_o[49:18];
        got.slice_end        = m_axis_tdata_o[81:50];
        got.remaining_before = m_axis_tdata_o[97:82];
        got.process_finished = m_axis_tdata_o[98];
        got.queue_count      = m_axis_tdata_o[103:99];
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("unexpected result word: %s", describe(got));
          end
        end else begin
          want = owed_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
      end
      // One long hold-off lets the scheduler fill up and stall its input.
      if (pressure_on && hold_count < HoldOffCycles) begin
        hold_count      <= hold_count + 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
        $display("no word moved for %0d cycles", QuietLimit);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_req(input logic [1:0] op, input logic [rrss_pkg::IdW-1:0] id,
                           input logic [rrss_pkg::RemW-1:0] burst);
    pending_reqs.push_back(sched_req_t'{op, id, burst});
  endtask

  task automatic settle();
    @(negedge clk_i);
    while (pending_reqs.size() != 0 || s_axis_tvalid_i || owed_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_register(input rrss_pkg::cfg_idx_e idx,
                                input logic [rrss_pkg::CfgW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    if (idx == rrss_pkg::CFG_QUANTUM) begin
      slice_limit = value;
    end else begin
      run_to_completion = value[0];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [rrss_pkg::RemW-1:0] pick_length();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 7) return rrss_pkg::RemW'($urandom_range(1, 8));
    if (sel < 9) return rrss_pkg::RemW'($urandom_range(1, 65535));
    return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0001;
  endfunction

  // Mostly adds and runs with random content, plus clears, reserved codes and bad lengths.
  task automatic random_phase(input int unsigned n);
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        queue_req(rrss_pkg::OP_CLEAR, rrss_pkg::IdW'($urandom), rrss_pkg::RemW'($urandom));
      end else if (pick < 6) begin
        queue_req(OpReserved, rrss_pkg::IdW'($urandom), rrss_pkg::RemW'($urandom));
      end else if (pick < 10) begin
        queue_req(rrss_pkg::OP_ADD, rrss_pkg::IdW'($urandom), '0);
      end else if (pick < 55) begin
        queue_req(rrss_pkg::OP_ADD, rrss_pkg::IdW'($urandom), pick_length());
      end else begin
        queue_req(rrss_pkg::OP_RUN, rrss_pkg::IdW'($urandom), rrss_pkg::RemW'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words under the reset settings: quantum one, round robin.
    queue_req(rrss_pkg::OP_RUN, 16'h0000, 16'h0000);
    queue_req(rrss_pkg::OP_ADD, 16'h0000, 16'h0000);
    queue_req(rrss_pkg::OP_ADD, 16'hFFFF, 16'hFFFF);
    queue_req(rrss_pkg::OP_ADD, 16'h0000, 16'h0001);
    queue_req(OpReserved, 16'hFFFF, 16'hFFFF);
    queue_req(rrss_pkg::OP_RUN, 16'h0000, 16'h0000);
    queue_req(rrss_pkg::OP_RUN, 16'hFFFF, 16'hFFFF);
    queue_req(rrss_pkg::OP_CLEAR, 16'h0000, 16'h0000);
    for (int i = 0; i < Depth; i++) begin
      queue_req(rrss_pkg::OP_ADD, rrss_pkg::IdW'(16'h1111 * i), rrss_pkg::RemW'(i + 1));
    end
    // With the queue full, a zero length must still report the bad length.
    queue_req(rrss_pkg::OP_ADD, 16'hABCD, 16'h0005);
    queue_req(rrss_pkg::OP_ADD, 16'hABCD, 16'h0000);
    queue_req(rrss_pkg::OP_RUN, 16'h0000, 16'h0000);
    queue_req(rrss_pkg::OP_CLEAR, 16'h0000, 16'h0000);
    settle();

    write_register(rrss_pkg::CFG_QUANTUM, 16'h0000);
    random_phase(RandomItems);
    settle();

    send_idle_pct = 63;
    recv_idle_pct = 21;
    write_register(rrss_pkg::CFG_QUANTUM, rrss_pkg::CfgW'($urandom_range(2, 7)));
    random_phase(RandomItems);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_register(rrss_pkg::CFG_FIFO, 16'h0001);
    write_register(rrss_pkg::CFG_QUANTUM, 16'hFFFF);
    random_phase(RandomItems);
    pressure_on <= 1'b1;
    settle();

    write_register(rrss_pkg::CFG_FIFO, 16'h0000);
    random_phase(RandomItems);
    settle();

    // Run-to-completion slices of the longest length, then runs on an emptied queue.
    write_register(rrss_pkg::CFG_FIFO, 16'h0001);
    queue_req(rrss_pkg::OP_CLEAR, 16'h0000, 16'h0000);
    for (int unsigned i = 0; i < LongSlicePairs; i++) begin
      queue_req(rrss_pkg::OP_ADD, rrss_pkg::IdW'($urandom), 16'hFFFF);
      queue_req(rrss_pkg::OP_RUN, 16'h0000, 16'h0000);
    end
    queue_req(rrss_pkg::OP_RUN, 16'h0000, 16'h0000);
    queue_req(rrss_pkg::OP_ADD, 16'h5A5A, 16'h0003);
    queue_req(rrss_pkg::OP_RUN, 16'h0000, 16'h0000);
    queue_req(rrss_pkg::OP_CLEAR, 16'h0000, 16'h0000);
    queue_req(rrss_pkg::OP_RUN, 16'h0000, 16'h0000);
    settle();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
